>>> rtl/twd_pkg.sv
// Shared types and constants of the trie word dictionary.
// Used by twd_front, twd_queue, twd_back and trie_word_dictionary.
package twd_pkg;

    localparam int POOL_NODES  = 16384;
    localparam int SLOTS       = 27;
    localparam int OTHER_SLOT  = 26;
    localparam int NODE_W      = $clog2(POOL_NODES);
    localparam int USED_W      = $clog2(POOL_NODES + 1);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int ADDR_W      = $clog2(POOL_NODES * SLOTS);
    localparam int CH_W        = 8;
    localparam int COUNT_W     = 18;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CH_W-1:0] CH_UPPER_A = 8'd65;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'd90;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'd97;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'd122;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [SLOT_W-1:0] slot;
    } t_parent;

endpackage

>>> rtl/twd_front.sv
// Input stage: accepts one character word, folds it to a trie slot, registers it.
// Depends on twd_pkg.
module twd_front import twd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_mode,
    input  logic [CH_W-1:0] i_ch,
    input  logic            i_last,
    output logic            o_valid,
    output t_item           o_item,
    input  logic            i_ready
);

    logic              r_valid;
    logic              n_valid;
    t_item             r_item;
    logic [SLOT_W-1:0] slot;
    logic              accept;

    always_comb begin
        if (i_ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            slot = SLOT_W'(i_ch - CH_UPPER_A);
        end else if (i_ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            slot = SLOT_W'(i_ch - CH_LOWER_A);
        end else begin
            slot = SLOT_W'(OTHER_SLOT);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{mode: i_mode, slot: slot, last: i_last};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/twd_queue.sv
// Short queue of classified characters between the front stage and the trie walker.
// Depends on twd_pkg.
module twd_queue import twd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/twd_back.sv
// Trie walker: child-link, parent and word-end memories, node allocation, result register.
// Depends on twd_pkg.
module twd_back import twd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic               o_overflow,
    output logic [COUNT_W-1:0] o_word_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LINK = 2'd1;
    localparam logic [1:0] S_PAR  = 2'd2;
    localparam logic [1:0] S_FLAG = 2'd3;

    logic [1:0]         r_state,      n_state;
    t_item              r_item,       n_item;
    logic [NODE_W-1:0]  r_cur,        n_cur;
    logic               r_miss,       n_miss;
    logic               r_ovf,        n_ovf;
    logic [USED_W-1:0]  r_nodes_used, n_nodes_used;
    logic [COUNT_W-1:0] r_count,      n_count;
    logic [ADDR_W-1:0]  r_addr,       n_addr;
    logic               r_out_valid,  n_out_valid;
    logic               r_out_found,  n_out_found;
    logic               r_out_ovf,    n_out_ovf;
    logic [COUNT_W-1:0] r_out_count,  n_out_count;

    logic [NODE_W-1:0]  r_links [POOL_NODES*SLOTS];
    t_parent            r_parents [POOL_NODES];
    logic               r_ends [POOL_NODES];
    logic [NODE_W-1:0]  r_link_q;
    t_parent            r_par_q;
    logic               r_end_q;

    logic               link_re;
    logic               link_we;
    logic               par_re;
    logic               par_we;
    logic               end_re;
    logic               end_we;
    logic [NODE_W-1:0]  end_ra;
    logic [NODE_W-1:0]  end_wa;
    logic               end_wd;
    logic [NODE_W-1:0]  free_node;
    logic               room;
    logic               link_hit;
    logic               alloc;
    logic               walk_ok;

    assign free_node = r_nodes_used[NODE_W-1:0];
    assign room      = (r_nodes_used < USED_W'(POOL_NODES));
    assign link_hit  = (r_link_q != '0) && (USED_W'(r_link_q) < r_nodes_used)
                       && (r_par_q == t_parent'{parent: r_cur, slot: r_item.slot});
    assign walk_ok   = !r_miss && !r_ovf;
    assign o_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_cur        = r_cur;
        n_miss       = r_miss;
        n_ovf        = r_ovf;
        n_nodes_used = r_nodes_used;
        n_count      = r_count;
        n_addr       = r_addr;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_ovf    = r_out_ovf;
        n_out_count  = r_out_count;
        link_re      = 1'b0;
        link_we      = 1'b0;
        par_re       = 1'b0;
        par_we       = 1'b0;
        end_re       = 1'b0;
        end_we       = 1'b0;
        end_ra       = r_cur;
        end_wa       = r_cur;
        end_wd       = 1'b0;
        alloc        = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item = i_item;
                    n_addr = ADDR_W'(r_cur) * ADDR_W'(SLOTS) + ADDR_W'(i_item.slot);
                    if (!walk_ok) begin
                        if (i_item.last) begin
                            end_re  = 1'b1;
                            n_state = S_FLAG;
                        end
                    end else begin
                        link_re = 1'b1;
                        n_state = S_LINK;
                    end
                end
            end
            S_LINK: begin
                par_re  = 1'b1;
                n_state = S_PAR;
            end
            S_PAR: begin
                if (link_hit) begin
                    n_cur = r_link_q;
                end else if (r_item.mode == MODE_CHECK) begin
                    n_miss = 1'b1;
                end else if (room) begin
                    alloc        = 1'b1;
                    link_we      = 1'b1;
                    par_we       = 1'b1;
                    end_we       = 1'b1;
                    end_wa       = free_node;
                    end_wd       = 1'b0;
                    n_cur        = free_node;
                    n_nodes_used = r_nodes_used + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                if (r_item.last) begin
                    end_re  = 1'b1;
                    end_ra  = n_cur;
                    n_state = S_FLAG;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLAG: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    if (r_item.mode == MODE_CHECK) begin
                        n_out_found = walk_ok && r_end_q && (r_cur != '0);
                        n_out_ovf   = 1'b0;
                        n_out_count = r_count;
                    end else begin
                        n_out_ovf   = r_ovf;
                        n_out_found = walk_ok;
                        if (walk_ok) begin
                            end_we = 1'b1;
                            end_wa = r_cur;
                            end_wd = 1'b1;
                            if (r_count != COUNT_MAX) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        n_out_count = n_count;
                    end
                    n_cur   = '0;
                    n_miss  = 1'b0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_miss       <= 1'b0;
            r_ovf        <= 1'b0;
            r_nodes_used <= USED_W'(1);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_miss       <= n_miss;
            r_ovf        <= n_ovf;
            r_nodes_used <= n_nodes_used;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_addr      <= n_addr;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        r_out_count <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_links[r_addr] <= free_node;
        end
        if (link_re) begin
            r_link_q <= r_links[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_parents[free_node] <= '{parent: r_cur, slot: r_item.slot};
        end
        if (par_re) begin
            r_par_q <= r_parents[r_link_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_we) begin
            r_ends[end_wa] <= end_wd;
        end
        if (end_re) begin
            r_end_q <= r_ends[end_ra];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_overflow   = r_out_ovf;
    assign o_word_count = r_out_count;

    a_pool_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used != '0) && (r_nodes_used <= USED_W'(POOL_NODES)))
        else $error("node count out of range");

    a_cursor_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        USED_W'(r_cur) < r_nodes_used)
        else $error("cursor points past allocated nodes");

    a_one_stop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_miss && r_ovf))
        else $error("missing path and overflow both set");

    a_alloc_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |=> (r_nodes_used == $past(r_nodes_used) + 1'b1) && (r_cur != '0))
        else $error("allocation did not advance node count and cursor");

    a_result_from_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FLAG))
        else $error("result raised outside word-end step");

endmodule

>>> rtl/trie_word_dictionary.sv
// Trie word dictionary, top level.
// Depends on twd_pkg, twd_front, twd_queue and twd_back.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one character word per
//   handshake: i_mode (0 insert, 1 check), raw byte i_ch, i_last on the
//   final character. Letters fold case-insensitively; other bytes share
//   one slot.
//   Output channel (o_valid / i_ready) carries one result per word, after
//   its last character: o_found, o_overflow, o_word_count (saturating).
//   Walker steps: a walked character takes a link read, a parent-check
//   read and an update; a final character adds a word-end flag read and,
//   on insert, its mark. Once a word has stopped on a missing path or a
//   full pool, its remaining characters skip the reads, and the last one
//   takes only the flag read. The walker takes one character at a time.
//   A last character passes the front register, the queue, the walker
//   steps and the result register before o_valid.
//   Reset: the trie is empty, the count is zero; no memory sweep is run.
//   Receiver stall: the result register holds; front stage and queue keep
//   taking characters until the queue fills.
module trie_word_dictionary import twd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [CH_W-1:0]    i_ch,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic               o_overflow,
    output logic [COUNT_W-1:0] o_word_count
);

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  queue_valid;
    logic  queue_ready;
    t_item queue_item;

    twd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_ch    (i_ch),
        .i_last  (i_last),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (front_ready)
    );

    twd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    twd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .o_ready      (queue_ready),
        .i_item       (queue_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_overflow   (o_overflow),
        .o_word_count (o_word_count)
    );

endmodule
